// File: sv/pbdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pbdc_pkg;

    localparam int MAX_PATHS    = 256;
    localparam int MAX_VERTICES = 64;
    localparam int MIN_VERTICES = 3;
    localparam int MIN_PATHS    = 2;

    localparam int COORD_W = 64;
    localparam int SEEN_W  = 9;
    localparam int VC_W    = $clog2(MAX_VERTICES + 2);
    localparam int PC_W    = $clog2(MAX_PATHS + 2);
    localparam int DRAIN_W = $clog2(MAX_PATHS + 1);

    typedef logic signed [COORD_W-1:0] coord_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

    typedef enum logic [2:0] {
        STATUS_OK    = 3'd0,
        STATUS_FEW   = 3'd1,
        STATUS_MANY  = 3'd2,
        STATUS_SHORT = 3'd3,
        STATUS_LONG  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DRAIN,
        S_RESULT
    } state_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        logic   path_end;
        logic   set_end;
    } in_beat_t;

    typedef struct packed {
        logic              all_disjoint;
        status_t           status;
        logic [SEEN_W-1:0] paths_seen;
    } out_beat_t;

    typedef struct packed {
        coord_t left;
        coord_t right;
        coord_t top;
        coord_t bottom;
    } box_t;

    // One path box travelling down the cell chain.
    typedef struct packed {
        logic valid;
        logic placed;
        logic hit;
        box_t box;
    } probe_t;

    typedef struct packed {
        status_t           status;
        logic [SEEN_W-1:0] seen;
    } summary_t;

    // Inclusive overlap: shared edges or corners count.
    function automatic logic boxes_overlap(box_t a, box_t b);
        logic ovl_x;
        logic ovl_y;
        ovl_x = (a.left <= b.right) && (b.left <= a.right)
             && (a.left <= a.right) && (b.left <= b.right);
        ovl_y = (a.top <= b.bottom) && (b.top <= a.bottom)
             && (a.top <= a.bottom) && (b.top <= b.bottom);
        return ovl_x && ovl_y;
    endfunction

endpackage

`default_nettype wire

// File: sv/pbdc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pbdc_front (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                accept,
    input  pbdc_pkg::in_beat_t beat,
    output pbdc_pkg::probe_t   probe,
    output pbdc_pkg::summary_t summary
);

    pbdc_pkg::coord_t min_x_reg, min_x_next, max_x_reg, max_x_next;
    pbdc_pkg::coord_t min_y_reg, min_y_next, max_y_reg, max_y_next;
    pbdc_pkg::coord_t min_x_upd, max_x_upd, min_y_upd, max_y_upd;
    logic [pbdc_pkg::VC_W-1:0] vc_reg, vc_next, vc_inc;
    logic [pbdc_pkg::PC_W-1:0] pc_reg, pc_next, pc_inc, pc_upd;
    pbdc_pkg::status_t err_reg, err_next, err_upd;
    pbdc_pkg::probe_t  probe_reg, probe_next;
    logic path_done;

    always_comb begin
        path_done = beat.path_end | beat.set_end;

        min_x_upd = (beat.point_x < min_x_reg) ? beat.point_x : min_x_reg;
        max_x_upd = (beat.point_x > max_x_reg) ? beat.point_x : max_x_reg;
        min_y_upd = (beat.point_y < min_y_reg) ? beat.point_y : min_y_reg;
        max_y_upd = (beat.point_y > max_y_reg) ? beat.point_y : max_y_reg;

        // Saturate one past the limit so a long path stays detectable.
        vc_inc = (vc_reg <= pbdc_pkg::VC_W'(pbdc_pkg::MAX_VERTICES))
               ? vc_reg + 1'b1 : vc_reg;
        pc_inc = (pc_reg <= pbdc_pkg::PC_W'(pbdc_pkg::MAX_PATHS))
               ? pc_reg + 1'b1 : pc_reg;

        err_upd = err_reg;
        if (path_done && err_reg == pbdc_pkg::STATUS_OK) begin
            if (vc_inc < pbdc_pkg::VC_W'(pbdc_pkg::MIN_VERTICES)) begin
                err_upd = pbdc_pkg::STATUS_SHORT;
            end else if (vc_inc > pbdc_pkg::VC_W'(pbdc_pkg::MAX_VERTICES)) begin
                err_upd = pbdc_pkg::STATUS_LONG;
            end
        end
        pc_upd = path_done ? pc_inc : pc_reg;

        if (pc_upd < pbdc_pkg::PC_W'(pbdc_pkg::MIN_PATHS)) begin
            summary.status = pbdc_pkg::STATUS_FEW;
        end else if (pc_upd > pbdc_pkg::PC_W'(pbdc_pkg::MAX_PATHS)) begin
            summary.status = pbdc_pkg::STATUS_MANY;
        end else begin
            summary.status = err_upd;
        end
        summary.seen = (pc_upd > pbdc_pkg::PC_W'(pbdc_pkg::MAX_PATHS))
                     ? pbdc_pkg::SEEN_W'(pbdc_pkg::MAX_PATHS)
                     : pbdc_pkg::SEEN_W'(pc_upd);

        probe_next.valid      = accept && path_done;
        probe_next.placed     = 1'b0;
        probe_next.hit        = 1'b0;
        probe_next.box.left   = min_x_upd;
        probe_next.box.right  = max_x_upd;
        probe_next.box.top    = min_y_upd;
        probe_next.box.bottom = max_y_upd;

        min_x_next = min_x_reg;
        max_x_next = max_x_reg;
        min_y_next = min_y_reg;
        max_y_next = max_y_reg;
        vc_next    = vc_reg;
        pc_next    = pc_reg;
        err_next   = err_reg;
        if (accept) begin
            if (path_done) begin
                // Drop the running box; it leaves as a probe.
                min_x_next = pbdc_pkg::COORD_MAX;
                max_x_next = pbdc_pkg::COORD_MIN;
                min_y_next = pbdc_pkg::COORD_MAX;
                max_y_next = pbdc_pkg::COORD_MIN;
                vc_next    = '0;
                pc_next    = beat.set_end ? '0 : pc_inc;
                err_next   = beat.set_end ? pbdc_pkg::STATUS_OK : err_upd;
            end else begin
                min_x_next = min_x_upd;
                max_x_next = max_x_upd;
                min_y_next = min_y_upd;
                max_y_next = max_y_upd;
                vc_next    = vc_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_x_reg <= pbdc_pkg::COORD_MAX;
            max_x_reg <= pbdc_pkg::COORD_MIN;
            min_y_reg <= pbdc_pkg::COORD_MAX;
            max_y_reg <= pbdc_pkg::COORD_MIN;
            vc_reg    <= '0;
            pc_reg    <= '0;
            err_reg   <= pbdc_pkg::STATUS_OK;
            probe_reg <= '0;
        end else begin
            min_x_reg <= min_x_next;
            max_x_reg <= max_x_next;
            min_y_reg <= min_y_next;
            max_y_reg <= max_y_next;
            vc_reg    <= vc_next;
            pc_reg    <= pc_next;
            err_reg   <= err_next;
            probe_reg <= probe_next;
        end
    end

    assign probe = probe_reg;

endmodule

`default_nettype wire

// File: sv/pbdc_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module pbdc_cell (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              clear,
    input  pbdc_pkg::probe_t probe_in,
    output pbdc_pkg::probe_t probe_out
);

    logic             occ_reg, occ_next;
    pbdc_pkg::box_t   box_reg, box_next;
    pbdc_pkg::probe_t out_reg, out_next;
    logic             live, store;

    always_comb begin
        live     = probe_in.valid && !probe_in.placed;
        store    = live && !occ_reg;
        out_next = probe_in;
        box_next = box_reg;
        if (store) begin
            // Park the box here; it rides on without further compares.
            out_next.placed = 1'b1;
            box_next        = probe_in.box;
        end else if (live) begin
            out_next.hit = probe_in.hit
                         | pbdc_pkg::boxes_overlap(probe_in.box, box_reg);
        end
        occ_next = clear ? 1'b0 : (occ_reg | store);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
            out_reg <= '0;
        end else begin
            occ_reg <= occ_next;
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        box_reg <= box_next;
    end

    assign probe_out = out_reg;

endmodule

`default_nettype wire

// File: sv/path_bbox_pairwise_disjoint_check_unit.sv
// Throughput: one vertex beat per cycle inside a set; s_ready drops from the set-end
// beat until the result beat is taken, as the last box walks the chain of MAX_PATHS cells.
// Reset: aresetn is synchronous, active low; it clears the running box, the counts,
// every cell's occupied flag and the result state. Stored boxes are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module path_bbox_pairwise_disjoint_check_unit (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  pbdc_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output pbdc_pkg::out_beat_t m_data
);

    // Probe links: link[0] leaves the front end, link[i+1] leaves cell i.
    pbdc_pkg::probe_t link [0:pbdc_pkg::MAX_PATHS];
    pbdc_pkg::probe_t tail;
    pbdc_pkg::summary_t summary;

    pbdc_pkg::state_t  state_reg, state_next;
    logic [pbdc_pkg::DRAIN_W-1:0] cnt_reg, cnt_next;
    logic              sticky_reg, sticky_next;
    pbdc_pkg::status_t status_reg, status_next;
    logic [pbdc_pkg::SEEN_W-1:0] seen_reg, seen_next;
    pbdc_pkg::out_beat_t out_reg, out_next;

    logic accept;
    logic clear;

    // Front end: running box, counts and per-path error of the set.
    pbdc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .beat    (s_data),
        .probe   (link[0]),
        .summary (summary)
    );

    // Chain of cells: each finished path box enters cell 0 and moves one cell per
    // cycle. It is tested against every box parked ahead of it and parks in the
    // first free cell, so each pair of boxes meets exactly once.
    for (genvar i = 0; i < pbdc_pkg::MAX_PATHS; i++) begin : g_cell
        pbdc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .clear     (clear),
            .probe_in  (link[i]),
            .probe_out (link[i+1])
        );
    end

    assign tail = link[pbdc_pkg::MAX_PATHS];

    always_comb begin
        s_ready = (state_reg == pbdc_pkg::S_IDLE);
        m_valid = (state_reg == pbdc_pkg::S_RESULT);
        accept  = s_valid && s_ready;
        clear   = m_valid && m_ready;

        // Collect overlap flags of probes leaving the chain; drop them once
        // the result beat is taken.
        sticky_next = clear ? 1'b0 : (sticky_reg | (tail.valid && tail.hit));

        state_next  = state_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        seen_next   = seen_reg;
        out_next    = out_reg;

        case (state_reg)
            pbdc_pkg::S_IDLE: begin
                if (accept && s_data.set_end) begin
                    // Hold the set summary while the last probe drains.
                    state_next  = pbdc_pkg::S_DRAIN;
                    cnt_next    = pbdc_pkg::DRAIN_W'(pbdc_pkg::MAX_PATHS);
                    status_next = summary.status;
                    seen_next   = summary.seen;
                end
            end
            pbdc_pkg::S_DRAIN: begin
                if (cnt_reg == '0) begin
                    // Last probe is being folded into the flag at this edge.
                    state_next            = pbdc_pkg::S_RESULT;
                    out_next.all_disjoint = (status_reg == pbdc_pkg::STATUS_OK)
                                          && !sticky_next;
                    out_next.status       = status_reg;
                    out_next.paths_seen   = seen_reg;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            pbdc_pkg::S_RESULT: begin
                if (m_ready) begin
                    state_next = pbdc_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = pbdc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= pbdc_pkg::S_IDLE;
            cnt_reg    <= '0;
            sticky_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            sticky_reg <= sticky_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        seen_reg   <= seen_next;
        out_reg    <= out_next;
    end

    assign m_data = out_reg;

    a_no_overlap_sides: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result side open at once");

    a_set_end_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.set_end |=> !s_ready && !m_valid)
        else $error("set end did not start the drain");

    a_reopen_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> s_ready && !m_valid)
        else $error("input side not reopened after result beat");

    a_disjoint_needs_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_data.all_disjoint || m_data.status == pbdc_pkg::STATUS_OK)
        else $error("disjoint reported with error status");

    a_chain_empty_at_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == pbdc_pkg::S_RESULT |-> !tail.valid)
        else $error("probe still leaving chain while result shown");

endmodule

`default_nettype wire
